// File: rtl/frp_pkg.sv
// Package for the fraction reducer: widths, controller states, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package frp_pkg;
  localparam int VW = 32;
  localparam int DW = 4 * ((VW * 3 + 9) / 10 + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD, ST_DIVN, ST_DIVD, ST_FIX, ST_CVTN, ST_CHKN, ST_CVTD, ST_CHKD, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic divn_init;
    logic divd_init;
    logic div_step;
    logic fix;
    logic cvtn_init;
    logic cvtd_init;
    logic cvt_step;
    logic chk_init;
    logic chk_step;
    logic chkn_done;
    logic chkd_done;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic cvt_done;
    logic chk_done;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/frp_ctrl.sv
// Controller state machine for the fraction reducer.
// Depends on frp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frp_ctrl import frp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire sts_t sts,
  output logic      busy,
  output logic      out_set,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_GCD;
      ST_GCD:  if (sts.gcd_done) state_nxt = ST_DIVN;
      ST_DIVN: if (sts.div_done) state_nxt = ST_DIVD;
      ST_DIVD: if (sts.div_done) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_CVTN;
      ST_CVTN: if (sts.cvt_done) state_nxt = ST_CHKN;
      ST_CHKN: if (sts.chk_done) state_nxt = ST_CVTD;
      ST_CVTD: if (sts.cvt_done) state_nxt = ST_CHKD;
      ST_CHKD: if (sts.chk_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    out_set = 1'b0;
    case (state_r)
      ST_IDLE: cmd.load = in_fire;
      ST_GCD: begin
        cmd.gcd_step = 1'b1;
        cmd.divn_init = sts.gcd_done;
      end
      ST_DIVN: begin
        cmd.div_step = 1'b1;
        cmd.divd_init = sts.div_done;
      end
      ST_DIVD: cmd.div_step = 1'b1;
      ST_FIX: cmd.fix = 1'b1;
      ST_CVTN: begin
        cmd.cvt_step = 1'b1;
        cmd.chk_init = sts.cvt_done;
      end
      ST_CHKN: begin
        cmd.chk_step = 1'b1;
        cmd.chkn_done = sts.chk_done;
        cmd.cvtd_init = sts.chk_done;
      end
      ST_CVTD: begin
        cmd.cvt_step = 1'b1;
        cmd.chk_init = sts.cvt_done;
      end
      ST_CHKD: begin
        cmd.chk_step = 1'b1;
        cmd.chkd_done = sts.chk_done;
      end
      ST_OUT: out_set = out_free;
      default: cmd = '0;
    endcase
    if (state_r == ST_FIX) cmd.cvtn_init = 1'b1;
  end
endmodule
`default_nettype wire

// File: rtl/frp_dp.sv
// Datapath for the fraction reducer: binary GCD, restoring dividers,
// double-dabble BCD conversion and digit palindrome check. Depends on frp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module frp_dp import frp_pkg::*; (
  input  wire logic          clk,
  input  wire logic [VW-1:0] num_i,
  input  wire logic [VW-1:0] den_i,
  input  wire cmd_t          cmd,
  output sts_t               sts,
  output logic [VW-1:0]      num_o,
  output logic [VW-2:0]      den_o,
  output logic               npal_o,
  output logic               dpal_o
);
  localparam int CW = $clog2(VW + 1);
  localparam int KW = $clog2(DW / 4 + 1);

  logic [VW-1:0] mn_r, md_r, ga_r, gb_r, qn_r, qd_r, g_r;
  logic [CW-1:0] sh_r, cnt_r;
  logic          ngn_r, dgn_r, gdone_r;
  logic [VW-1:0] dq_r;
  logic [VW:0]   rem_r;
  logic [VW-1:0] cv_r;
  logic [DW-1:0] bcd_r;
  logic [KW-1:0] lo_r, hi_r;
  logic          pal_r;
  logic [VW-1:0] ob_r;
  logic          neg_r;

  logic [VW-1:0] lim;
  assign lim = {1'b0, {(VW-1){1'b1}}};

  // gcd: ga/gb odd-even reduction
  logic [VW-1:0] diff;
  assign diff = (ga_r > gb_r) ? ga_r - gb_r : gb_r - ga_r;
  assign sts.gcd_done = gdone_r;

  logic [VW:0] trial;
  assign trial = {rem_r[VW-1:0], dq_r[VW-1]} - {1'b0, g_r};
  assign sts.div_done = (cnt_r == CW'(VW));

  assign sts.cvt_done = (cnt_r == CW'(VW));
  assign sts.chk_done = (hi_r <= lo_r) || !pal_r;

  // double dabble adjust
  logic [DW-1:0] adj;
  always_comb begin
    for (int k = 0; k < DW / 4; k++) begin
      adj[k*4 +: 4] = (bcd_r[k*4 +: 4] > 4'd4) ? bcd_r[k*4 +: 4] + 4'd3 : bcd_r[k*4 +: 4];
    end
  end

  // most significant nonzero digit index
  logic [KW-1:0] top;
  always_comb begin
    top = '0;
    for (int k = 0; k < DW / 4; k++) begin
      if (bcd_r[k*4 +: 4] != 4'd0) top = KW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ngn_r <= num_i[VW-1];
      dgn_r <= den_i[VW-1];
      mn_r  <= num_i[VW-1] ? -num_i : num_i;
      md_r  <= den_i[VW-1] ? -den_i : den_i;
      ga_r  <= num_i[VW-1] ? -num_i : num_i;
      gb_r  <= den_i[VW-1] ? -den_i : den_i;
      sh_r  <= '0;
      gdone_r <= (num_i == '0) || (den_i == '0);
    end else if (cmd.gcd_step && !gdone_r) begin
      if (ga_r == gb_r) gdone_r <= 1'b1;
      else if (!ga_r[0] && !gb_r[0]) begin
        ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; sh_r <= sh_r + 1'b1;
      end else if (!ga_r[0]) ga_r <= ga_r >> 1;
      else if (!gb_r[0]) gb_r <= gb_r >> 1;
      else if (ga_r > gb_r) ga_r <= diff;
      else gb_r <= diff;
    end
    if (cmd.divn_init) begin
      g_r   <= ((mn_r == '0) || (md_r == '0)) ? VW'(1) : (ga_r << sh_r);
      dq_r  <= mn_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.divd_init) begin
      qn_r  <= dq_r;
      dq_r  <= md_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step && !sts.div_done) begin
      if (!trial[VW]) begin
        rem_r <= trial;
        dq_r  <= {dq_r[VW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[VW-1:0], dq_r[VW-1]};
        dq_r  <= {dq_r[VW-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.fix) begin
      neg_r <= (ngn_r != dgn_r) && (qn_r != '0);
      if (!((ngn_r != dgn_r) && (qn_r != '0)) && qn_r > lim) qn_r <= lim;
      qd_r  <= (dq_r > lim) ? lim : dq_r;
    end
    if (cmd.cvtn_init || cmd.cvtd_init) begin
      cv_r  <= cmd.cvtn_init ? ((!((ngn_r != dgn_r) && (qn_r != '0)) && qn_r > lim) ? lim : qn_r)
                             : qd_r;
      bcd_r <= '0;
      cnt_r <= '0;
    end else if (cmd.cvt_step && !sts.cvt_done) begin
      bcd_r <= {adj[DW-2:0], cv_r[VW-1]};
      cv_r  <= cv_r << 1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.chk_init) begin
      lo_r  <= '0;
      hi_r  <= top;
      pal_r <= 1'b1;
    end else if (cmd.chk_step && !sts.chk_done) begin
      if (bcd_r[lo_r*4 +: 4] != bcd_r[hi_r*4 +: 4]) pal_r <= 1'b0;
      lo_r <= lo_r + 1'b1;
      hi_r <= hi_r - 1'b1;
    end
    if (cmd.chkn_done) begin
      npal_o <= pal_r;
      ob_r   <= qn_r;
    end
    if (cmd.chkd_done) dpal_o <= pal_r;
  end

  assign num_o = neg_r ? -ob_r : ob_r;
  assign den_o = qd_r[VW-2:0];
endmodule
`default_nettype wire

// File: rtl/fraction_reduce_palindrome_core.sv
// Fraction reducer with decimal palindrome flags, one item at a time.
// Steps from accept to out_tvalid: binary GCD, numerator and denominator divisions,
// fix, numerator BCD conversion and digit check, denominator conversion and check,
// then the output step. in_tready is high only when idle, so a new item waits until
// the previous result has left the datapath for the output register.
// Reset: synchronous active-low rst_n returns the controller to idle, output empty.
// Depends on frp_pkg, frp_ctrl, frp_dp.
`timescale 1ns / 1ps
`default_nettype none
module fraction_reduce_palindrome_core import frp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // numerator_in[31:0], denominator_in[63:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // numerator_out[31:0], denominator_out[62:32],
                                       // npal[63], dpal[64], zero fill[71:65]
);
  cmd_t cmd;
  sts_t sts;
  logic busy, out_set, in_fire, npal, dpal;
  logic [VW-1:0] num_o;
  logic [VW-2:0] den_o;
  logic out_valid_r;
  logic [71:0] out_data_r;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  frp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(!out_valid_r || out_tready), .sts(sts),
    .busy(busy), .out_set(out_set), .cmd(cmd)
  );

  frp_dp u_dp (
    .clk(clk), .num_i(in_tdata[31:0]), .den_i(in_tdata[63:32]), .cmd(cmd), .sts(sts),
    .num_o(num_o), .den_o(den_o), .npal_o(npal), .dpal_o(dpal)
  );

  // output register frees the datapath while a result waits
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_set) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (out_set) out_data_r <= {7'd0, dpal, npal, den_o, num_o};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire
